// ===== rtl/c3f_pkg.sv =====
// ----------------------------------------------------------------------------
// c3f_pkg: shared constants and types of the 3x3 correlation filter
// Geometry limits, field widths, register indexes and the job record that
// travels from the window stage to the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package c3f_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int PIXEL_BITS  = 16;
    localparam int COEF_BITS   = 16;
    localparam int KSIZE       = 3;
    localparam int MAX_RESULTS = 4;

    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
    localparam int DIM_BITS       = 11;
    localparam int KROW_BITS      = 48;
    localparam int CFG_DATA_BITS  = 48;
    localparam int CFG_INDEX_BITS = 3;

    localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;
    localparam int PART_BITS = PROD_BITS + 2;
    localparam int FULL_BITS = PART_BITS + 2;
    localparam int SUM_BITS  = 35;

    localparam int FIFO_DEPTH    = 16;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH) + 1;
    localparam int OFF_BITS      = $clog2(MAX_RESULTS);
    localparam int PUSH_BITS     = $clog2(MAX_RESULTS + 1);

    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_TOP    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd4;

    typedef logic signed [PIXEL_BITS-1:0] pixel_t;
    typedef logic signed [COEF_BITS-1:0]  coef_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [PART_BITS-1:0]  part_t;
    typedef logic signed [FULL_BITS-1:0]  full_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic [ROW_BITS-1:0]          row_t;
    typedef logic [COL_BITS-1:0]          col_t;
    typedef logic [DIM_BITS-1:0]          dim_t;

    typedef pixel_t [KSIZE-1:0][KSIZE-1:0] win_t;

    typedef struct packed {
        row_t row;
        col_t col;
        logic last_of_run;
        logic image_done;
    } job_meta_t;

    typedef struct packed {
        win_t      pix;
        job_meta_t meta;
    } job_t;

endpackage

// ===== rtl/c3f_ifs.sv =====
// ----------------------------------------------------------------------------
// c3f_ifs: request channels of the 3x3 correlation filter
// Pixel input, result output and configuration write, each valid/ready.
// ----------------------------------------------------------------------------
interface c3f_pixel_if
    import c3f_pkg::*;
();
    logic   valid;
    logic   ready;
    pixel_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface c3f_result_if
    import c3f_pkg::*;
();
    logic valid;
    logic ready;
    row_t out_row;
    col_t out_col;
    sum_t filtered;
    logic last_of_run;
    logic image_done;

    modport source (output valid, output out_row, output out_col, output filtered,
                    output last_of_run, output image_done, input ready);
    modport sink   (input valid, input out_row, input out_col, input filtered,
                    input last_of_run, input image_done, output ready);
endinterface

interface c3f_cfg_if
    import c3f_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/c3f_ram.sv =====
// ----------------------------------------------------------------------------
// c3f_ram: generic single-write, single-read synchronous RAM
// Registered read; a read of the address being written returns the old word.
// ----------------------------------------------------------------------------
module c3f_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata <= mem_array[raddr];
    end

endmodule

// ===== rtl/conv3x3_zero_padded_image_filter.sv =====
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_image_filter: 3x3 zero-padded correlation filter
// Throughput: one pixel and one result per cycle while the result channel is
// ready, set by the line store port and the single nine-multiplier MAC pipeline;
// input stalls while more than eight results wait in the job queue. A pixel
// passes the input register, the job queue and the MAC registers before its
// first result. Reset: asynchronous, no clearing pass.
module conv3x3_zero_padded_image_filter
    import c3f_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    c3f_cfg_if.sink      cfg,
    c3f_pixel_if.sink    pixels,
    c3f_result_if.source results
);

    // configuration
    logic [KROW_BITS-1:0] kernel_reg [KSIZE];
    dim_t                 width_reg;
    dim_t                 height_reg;
    coef_t                coef [KSIZE][KSIZE];
    dim_t                 width_eff;
    dim_t                 height_eff;

    // raster counters and input stage
    row_t   row_count_reg;
    col_t   col_count_reg;
    logic   in_accept;
    logic   last_col;
    logic   last_row;

    logic   s1_valid_reg;
    pixel_t s1_pixel_reg;
    row_t   s1_row_reg;
    col_t   s1_col_reg;
    logic   s1_last_col_reg;
    logic   s1_last_row_reg;

    // line stores and forwarding
    pixel_t above_q;
    pixel_t two_above_q;
    pixel_t above_val;
    pixel_t two_above_val;
    logic   fwd_reg;
    pixel_t fwd_above_reg;
    pixel_t fwd_two_above_reg;

    // window and job generation
    win_t   win_reg;
    win_t   win_next;
    job_t   cand_job [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] cand_valid;
    logic [OFF_BITS-1:0]    cand_off [MAX_RESULTS];
    logic [PUSH_BITS-1:0]   push_count;
    logic                   later;

    // job queue
    job_t                     fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] fifo_count_reg;
    logic                     pop;

    // MAC pipeline
    logic      adv;
    logic      p0_valid_reg;
    job_t      p0_job_reg;
    logic      p1_valid_reg;
    prod_t     p1_prod_reg [KSIZE][KSIZE];
    prod_t     p1_prod_next [KSIZE][KSIZE];
    job_meta_t p1_meta_reg;
    logic      p2_valid_reg;
    part_t     p2_part_reg [KSIZE];
    part_t     p2_part_next [KSIZE];
    job_meta_t p2_meta_reg;
    full_t     full_sum;
    logic      res_valid_reg;
    sum_t      res_sum_reg;
    job_meta_t res_meta_reg;

    function automatic win_t align_window(win_t win, logic shift_row, logic shift_col);
        win_t res;
        int   rr;
        int   cc;
        res = '0;
        for (int dr = 0; dr < KSIZE; dr++)
        begin
            for (int dc = 0; dc < KSIZE; dc++)
            begin
                rr = dr + int'(shift_row);
                cc = dc + int'(shift_col);
                if (rr < KSIZE && cc < KSIZE)
                begin
                    res[dr][dc] = win[rr][cc];
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KSIZE; i++)
            begin
                kernel_reg[i] <= '0;
            end
            width_reg  <= DIM_BITS'(MAX_WIDTH);
            height_reg <= DIM_BITS'(MAX_HEIGHT);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_KERNEL_TOP:    kernel_reg[0] <= cfg.data[KROW_BITS-1:0];
                REG_KERNEL_MIDDLE: kernel_reg[1] <= cfg.data[KROW_BITS-1:0];
                REG_KERNEL_BOTTOM: kernel_reg[2] <= cfg.data[KROW_BITS-1:0];
                REG_IMAGE_WIDTH:   width_reg     <= cfg.data[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT:  height_reg    <= cfg.data[DIM_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                coef[i][j] = kernel_reg[i][j*COEF_BITS +: COEF_BITS];
            end
        end
    end

    // zero acts as one, oversize as the maximum
    assign width_eff  = (width_reg == '0) ? DIM_BITS'(1) :
                        (width_reg > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : width_reg;
    assign height_eff = (height_reg == '0) ? DIM_BITS'(1) :
                        (height_reg > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : height_reg;

    // ------------------------------------------------------------------------
    // Input stage and raster counters
    // ------------------------------------------------------------------------
    // leave room for the jobs of the pixel in flight and of the new one
    assign pixels.ready = (fifo_count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2 * MAX_RESULTS));
    assign in_accept    = pixels.valid && pixels.ready;

    assign last_col = (DIM_BITS'(col_count_reg) + DIM_BITS'(1)) >= width_eff;
    assign last_row = (DIM_BITS'(row_count_reg) + DIM_BITS'(1)) >= height_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            if (in_accept)
            begin
                // forward when the store still being written is read again
                fwd_reg <= s1_valid_reg && (s1_col_reg == col_count_reg);
                if (last_col)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= last_row ? '0 : row_count_reg + ROW_BITS'(1);
                end
                else
                begin
                    col_count_reg <= col_count_reg + COL_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg      <= pixels.pixel;
            s1_row_reg        <= row_count_reg;
            s1_col_reg        <= col_count_reg;
            s1_last_col_reg   <= last_col;
            s1_last_row_reg   <= last_row;
            fwd_above_reg     <= s1_pixel_reg;
            fwd_two_above_reg <= above_val;
        end
    end

    // ------------------------------------------------------------------------
    // Line stores: read at request, write back in the cycle after, never later
    // ------------------------------------------------------------------------
    c3f_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_pixel_reg),
        .raddr (col_count_reg),
        .rdata (above_q)
    );

    c3f_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (above_val),
        .raddr (col_count_reg),
        .rdata (two_above_q)
    );

    assign above_val     = fwd_reg ? fwd_above_reg     : above_q;
    assign two_above_val = fwd_reg ? fwd_two_above_reg : two_above_q;

    // ------------------------------------------------------------------------
    // Window shift and job generation
    // ------------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            win_next[i][0] = (s1_col_reg == '0) ? '0 : win_reg[i][1];
            win_next[i][1] = (s1_col_reg == '0) ? '0 : win_reg[i][2];
        end
        win_next[0][2] = (s1_row_reg >= ROW_BITS'(2)) ? two_above_val : '0;
        win_next[1][2] = (s1_row_reg != '0) ? above_val : '0;
        win_next[2][2] = s1_pixel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        cand_valid[0] = s1_valid_reg && (s1_row_reg != '0) && (s1_col_reg != '0);
        cand_valid[1] = s1_valid_reg && (s1_row_reg != '0) && s1_last_col_reg;
        cand_valid[2] = s1_valid_reg && s1_last_row_reg && (s1_col_reg != '0);
        cand_valid[3] = s1_valid_reg && s1_last_row_reg && s1_last_col_reg;

        cand_job[0].pix  = align_window(win_next, 1'b0, 1'b0);
        cand_job[0].meta = '{row: s1_row_reg - ROW_BITS'(1), col: s1_col_reg - COL_BITS'(1),
                             last_of_run: 1'b0, image_done: 1'b0};
        cand_job[1].pix  = align_window(win_next, 1'b0, 1'b1);
        cand_job[1].meta = '{row: s1_row_reg - ROW_BITS'(1), col: s1_col_reg,
                             last_of_run: 1'b0, image_done: 1'b0};
        cand_job[2].pix  = align_window(win_next, 1'b1, 1'b0);
        cand_job[2].meta = '{row: s1_row_reg, col: s1_col_reg - COL_BITS'(1),
                             last_of_run: 1'b0, image_done: 1'b0};
        cand_job[3].pix  = align_window(win_next, 1'b1, 1'b1);
        cand_job[3].meta = '{row: s1_row_reg, col: s1_col_reg,
                             last_of_run: 1'b0, image_done: 1'b1};

        // mark the last job of this pixel
        later = 1'b0;
        for (int j = MAX_RESULTS - 1; j >= 0; j--)
        begin
            cand_job[j].meta.last_of_run = cand_valid[j] && !later;
            later = later || cand_valid[j];
        end

        // pack the jobs into consecutive queue slots
        push_count = '0;
        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            cand_off[j] = push_count[OFF_BITS-1:0];
            push_count  = push_count + PUSH_BITS'(cand_valid[j]);
        end
    end

    // ------------------------------------------------------------------------
    // Job queue
    // ------------------------------------------------------------------------
    assign pop = adv && (fifo_count_reg != '0);

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            if (cand_valid[j])
            begin
                fifo_mem_reg[FIFO_PTR_BITS'(wr_ptr_reg + FIFO_PTR_BITS'(cand_off[j]))]
                    <= cand_job[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_reg + FIFO_PTR_BITS'(push_count);
            rd_ptr_reg     <= rd_ptr_reg + FIFO_PTR_BITS'(pop);
            fifo_count_reg <= fifo_count_reg + FIFO_CNT_BITS'(push_count)
                              - FIFO_CNT_BITS'(pop);
        end
    end

    // ------------------------------------------------------------------------
    // MAC pipeline: fetch, multiply, row sums, final sum; stalls as a whole
    // ------------------------------------------------------------------------
    assign adv = !res_valid_reg || results.ready;

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                p1_prod_next[i][j] = prod_t'(signed'(p0_job_reg.pix[i][j]))
                                     * prod_t'(coef[i][j]);
            end
            p2_part_next[i] = part_t'(p1_prod_reg[i][0]) + part_t'(p1_prod_reg[i][1])
                              + part_t'(p1_prod_reg[i][2]);
        end
        full_sum = full_t'(p2_part_reg[0]) + full_t'(p2_part_reg[1])
                   + full_t'(p2_part_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p0_valid_reg  <= pop;
            p1_valid_reg  <= p0_valid_reg;
            p2_valid_reg  <= p1_valid_reg;
            res_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_job_reg   <= fifo_mem_reg[rd_ptr_reg];
            p1_prod_reg  <= p1_prod_next;
            p1_meta_reg  <= p0_job_reg.meta;
            p2_part_reg  <= p2_part_next;
            p2_meta_reg  <= p1_meta_reg;
            res_sum_reg  <= full_sum[SUM_BITS-1:0];
            res_meta_reg <= p2_meta_reg;
        end
    end

    assign results.valid       = res_valid_reg;
    assign results.out_row     = res_meta_reg.row;
    assign results.out_col     = res_meta_reg.col;
    assign results.filtered    = res_sum_reg;
    assign results.last_of_run = res_meta_reg.last_of_run;
    assign results.image_done  = res_meta_reg.image_done;

endmodule

// ===== verif/c3f_filter_checker.sv =====
// ----------------------------------------------------------------------------
// c3f_filter_checker: result predictor and comparator for the 3x3 filter
// Watches the configuration, pixel and result channels. Every accepted pixel
// runs through a local line store and window model, and the results it causes
// are queued as they arise. Every accepted result is compared with the
// oldest queued one. The failure count and queue depth go to the testbench.
// ----------------------------------------------------------------------------
module c3f_filter_checker
    import c3f_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    c3f_cfg_if    cfg,
    c3f_pixel_if  pixels,
    c3f_result_if results,
    output int    failures,
    output int    pending,
    output logic  frame_start
);

    typedef struct {
        row_t row;
        col_t col;
        sum_t filtered;
        logic last_of_run;
        logic image_done;
    } filter_result_t;

    filter_result_t       expected_results[$];
    logic [KROW_BITS-1:0] kernel_rows[KSIZE];
    dim_t                 width_reg;
    dim_t                 height_reg;
    pixel_t               store_above[MAX_WIDTH];
    pixel_t               store_two_above[MAX_WIDTH];
    pixel_t               window[KSIZE][KSIZE];
    int unsigned          row_pos;
    int unsigned          col_pos;
    int                   mismatches;

    function automatic int unsigned effective_dim(dim_t v, int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // window cells outside the 3x3 grid (row or column beyond the image) are zero
    function automatic longint neighbourhood_sum(int cr, int cc);
        longint acc;
        int     dr;
        int     dc;
        int     wr;
        int     wc;
        coef_t  k;
        acc = 0;
        for (dr = 0; dr < KSIZE; dr++)
        begin
            for (dc = 0; dc < KSIZE; dc++)
            begin
                wr = cr - 1 + dr;
                wc = cc - 1 + dc;
                if (wr >= 0 && wr < KSIZE && wc >= 0 && wc < KSIZE)
                begin
                    k = kernel_rows[dr][dc*COEF_BITS +: COEF_BITS];
                    acc += longint'(window[wr][wc]) * longint'(k);
                end
            end
        end
        return acc;
    endfunction

    task automatic queue_result(int unsigned r, int unsigned c, longint s, logic done);
        filter_result_t rec;
        rec.row         = row_t'(r);
        rec.col         = col_t'(c);
        rec.filtered    = sum_t'(s);
        rec.last_of_run = 1'b0;
        rec.image_done  = done;
        expected_results.push_back(rec);
    endtask

    task automatic predict_pixel(pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned ci;
        logic        last_col;
        logic        last_row;
        int          first;
        int          i;
        w        = effective_dim(width_reg, MAX_WIDTH);
        h        = effective_dim(height_reg, MAX_HEIGHT);
        r        = row_pos;
        c        = col_pos;
        ci       = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);
        first    = expected_results.size();

        // shift the window left; a new row starts with a zero margin
        for (i = 0; i < KSIZE; i++)
        begin
            window[i][0] = (c == 0) ? pixel_t'(0) : window[i][1];
            window[i][1] = (c == 0) ? pixel_t'(0) : window[i][2];
        end
        window[0][2]        = (r >= 2) ? store_two_above[ci] : pixel_t'(0);
        window[1][2]        = (r >= 1) ? store_above[ci] : pixel_t'(0);
        window[2][2]        = px;
        store_two_above[ci] = store_above[ci];
        store_above[ci]     = px;

        if (r >= 1)
        begin
            if (c >= 1)
                queue_result(r - 1, c - 1, neighbourhood_sum(1, 1), 1'b0);
            if (last_col)
                queue_result(r - 1, c, neighbourhood_sum(1, 2), 1'b0);
        end
        if (last_row)
        begin
            if (c >= 1)
                queue_result(r, c - 1, neighbourhood_sum(2, 1), 1'b0);
            if (last_col)
                queue_result(r, c, neighbourhood_sum(2, 2), 1'b1);
        end
        if (expected_results.size() > first)
            expected_results[expected_results.size() - 1].last_of_run = 1'b1;

        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    task automatic report_failure(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    task automatic check_result();
        filter_result_t want;
        if (expected_results.size() == 0)
        begin
            report_failure($sformatf("unexpected result row %0d col %0d sum %0d",
                results.out_row, results.out_col, results.filtered));
        end
        else
        begin
            want = expected_results.pop_front();
            if (results.out_row !== want.row || results.out_col !== want.col ||
                results.filtered !== want.filtered ||
                results.last_of_run !== want.last_of_run ||
                results.image_done !== want.image_done)
            begin
                report_failure({
                    $sformatf("result mismatch: expected row %0d col %0d sum %0d last %0b",
                              want.row, want.col, want.filtered, want.last_of_run),
                    $sformatf(" done %0b, got row %0d col %0d sum %0d last %0b done %0b",
                              want.image_done, results.out_row, results.out_col,
                              results.filtered, results.last_of_run, results.image_done)});
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_rows = '{default: '0};
            width_reg   = dim_t'(MAX_WIDTH);
            height_reg  = dim_t'(MAX_HEIGHT);
            window      = '{default: '0};
            row_pos     = 0;
            col_pos     = 0;
            mismatches  = 0;
            expected_results.delete();
            failures    <= 0;
            pending     <= 0;
            frame_start <= 1'b1;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_KERNEL_TOP:    kernel_rows[0] = cfg.data[KROW_BITS-1:0];
                    REG_KERNEL_MIDDLE: kernel_rows[1] = cfg.data[KROW_BITS-1:0];
                    REG_KERNEL_BOTTOM: kernel_rows[2] = cfg.data[KROW_BITS-1:0];
                    REG_IMAGE_WIDTH:   width_reg      = cfg.data[DIM_BITS-1:0];
                    REG_IMAGE_HEIGHT:  height_reg     = cfg.data[DIM_BITS-1:0];
                    default: ;
                endcase
            end
            if (results.valid && results.ready)
                check_result();
            if (pixels.valid && pixels.ready)
                predict_pixel(pixels.pixel);
            failures    <= mismatches;
            pending     <= expected_results.size();
            frame_start <= (row_pos == 0 && col_pos == 0);
        end
    end

endmodule

// ===== verif/tb_conv3x3_zero_padded_image_filter.sv =====
// ----------------------------------------------------------------------------
// tb_conv3x3_zero_padded_image_filter: stimulus and verdict for the 3x3 filter
// Directed images with extreme pixels and coefficients, single-pixel images,
// mid-image resizing, oversize dimensions, a steady stream with no idling,
// then random images with random idling on both sides. The checker predicts
// and compares.
// ----------------------------------------------------------------------------
module tb_conv3x3_zero_padded_image_filter;
    import c3f_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int IDLE_PERCENT   = 31;
    localparam int RANDOM_ITEMS   = 160;
    localparam int OVERSIZE_ITEMS = 16;
    localparam int STREAM_WIDTH   = 24;
    localparam int STREAM_HEIGHT  = 4;

    localparam pixel_t PIX_MIN  = pixel_t'(16'h8000);
    localparam pixel_t PIX_MAX  = pixel_t'(16'h7FFF);
    localparam coef_t  COEF_MIN = coef_t'(16'h8000);
    localparam coef_t  COEF_MAX = coef_t'(16'h7FFF);

    localparam pixel_t EDGE_PIXELS[8] = '{PIX_MIN, PIX_MAX, 16'sd0, -16'sd1, 16'sd1,
                                          PIX_MAX, PIX_MIN, 16'sh5A5A};

    logic clk = 1'b0;
    logic rst_n;
    logic steady;
    logic frame_start;
    int   failures;
    int   pending;
    int   cycles;
    int   pixels_sent;
    int   setups;
    int   random_items;

    c3f_cfg_if    cfg();
    c3f_pixel_if  pixels();
    c3f_result_if results();

    conv3x3_zero_padded_image_filter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pixels  (pixels),
        .results (results)
    );

    c3f_filter_checker filter_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pixels      (pixels),
        .results     (results),
        .failures    (failures),
        .pending     (pending),
        .frame_start (frame_start)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
        results.ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PERCENT);

    function automatic logic [KROW_BITS-1:0] pack_kernel_row(coef_t left, coef_t middle,
                                                             coef_t right);
        return {right, middle, left};
    endfunction

    function automatic coef_t random_coef();
        case ($urandom_range(0, 5))
            0:       return COEF_MIN;
            1:       return COEF_MAX;
            default: return coef_t'($urandom);
        endcase
    endfunction

    function automatic logic [KROW_BITS-1:0] random_kernel_row();
        return pack_kernel_row(random_coef(), random_coef(), random_coef());
    endfunction

    function automatic pixel_t random_pixel();
        case ($urandom_range(0, 7))
            0:       return PIX_MIN;
            1:       return PIX_MAX;
            2:       return pixel_t'(0);
            3:       return pixel_t'(-1);
            default: return pixel_t'($urandom);
        endcase
    endfunction

    // drop valid and hold until every queued result has come out
    task automatic pause_sender();
        pixels.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_setup(logic [KROW_BITS-1:0] top, logic [KROW_BITS-1:0] middle,
                               logic [KROW_BITS-1:0] bottom, dim_t w, dim_t h);
        logic [CFG_INDEX_BITS-1:0] regs[5];
        logic [CFG_DATA_BITS-1:0]  values[5];
        int                        i;
        regs   = '{REG_KERNEL_TOP, REG_KERNEL_MIDDLE, REG_KERNEL_BOTTOM,
                   REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
        values = '{top, middle, bottom, CFG_DATA_BITS'(w), CFG_DATA_BITS'(h)};
        pause_sender();
        // a pixel at the start of a row gives no result, so let the pipeline settle
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (i = 0; i < 5; i++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= regs[i];
            cfg.data  <= values[i];
            do
                @(posedge clk);
            while (!cfg.ready);
        end
        cfg.valid <= 1'b0;
        setups++;
    endtask

    task automatic send_pixel(pixel_t p);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            pixels.valid <= 1'b0;
            @(posedge clk);
        end
        pixels.valid <= 1'b1;
        pixels.pixel <= p;
        do
            @(posedge clk);
        while (!pixels.ready);
        pixels_sent++;
    endtask

    // send one request at a time until the counters wrap to a new image
    task automatic finish_image();
        do
        begin
            send_pixel(random_pixel());
            pixels.valid <= 1'b0;
            @(posedge clk);
        end
        while (!frame_start);
    endtask

    initial
    begin
        int          i;
        int          count;
        int          first_sent;
        int unsigned w_eff;
        dim_t        w;
        dim_t        h;

        rst_n         = 1'b0;
        steady        <= 1'b0;
        cfg.valid     <= 1'b0;
        cfg.index     <= REG_KERNEL_TOP;
        cfg.data      <= '0;
        pixels.valid  <= 1'b0;
        pixels.pixel  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // largest magnitude sum: full neighbourhood of minimum pixels and coefficients
        write_setup(pack_kernel_row(COEF_MIN, COEF_MIN, COEF_MIN),
                    pack_kernel_row(COEF_MIN, COEF_MIN, COEF_MIN),
                    pack_kernel_row(COEF_MIN, COEF_MIN, COEF_MIN), 11'd3, 11'd3);
        for (i = 0; i < 9; i++)
            send_pixel(PIX_MIN);

        write_setup(pack_kernel_row(COEF_MIN, COEF_MAX, 16'sd1),
                    pack_kernel_row(-16'sd1, COEF_MAX, COEF_MIN),
                    pack_kernel_row(16'sd2, -16'sd2, COEF_MAX), 11'd4, 11'd2);
        for (i = 0; i < 8; i++)
            send_pixel(EDGE_PIXELS[i]);

        // zero width and height act as one: single-pixel images
        write_setup(random_kernel_row(), random_kernel_row(), random_kernel_row(), 11'd0, 11'd0);
        send_pixel(PIX_MAX);
        send_pixel(PIX_MIN);

        // shrink mid-image so the column lies beyond the new last column
        write_setup(random_kernel_row(), random_kernel_row(), random_kernel_row(), 11'd4, 11'd3);
        for (i = 0; i < 6; i++)
            send_pixel(random_pixel());
        write_setup(random_kernel_row(), random_kernel_row(), random_kernel_row(), 11'd2, 11'd2);
        finish_image();

        // oversize width and height act as the maximum; shrink before the row ends
        write_setup(random_kernel_row(), random_kernel_row(), random_kernel_row(),
                    11'd2047, 11'd2047);
        for (i = 0; i < OVERSIZE_ITEMS; i++)
            send_pixel(random_pixel());
        write_setup(random_kernel_row(), random_kernel_row(), random_kernel_row(), 11'd2, 11'd1);
        finish_image();

        // long stream with no idling on either side
        steady <= 1'b1;
        write_setup(random_kernel_row(), random_kernel_row(), random_kernel_row(),
                    dim_t'(STREAM_WIDTH), dim_t'(STREAM_HEIGHT));
        for (i = 0; i < STREAM_WIDTH * STREAM_HEIGHT; i++)
            send_pixel(random_pixel());
        steady <= 1'b0;

        first_sent = pixels_sent;
        while (pixels_sent - first_sent < RANDOM_ITEMS)
        begin
            w     = dim_t'($urandom_range(0, 12));
            h     = dim_t'($urandom_range(0, 6));
            w_eff = (w == 0) ? 1 : w;
            count = w_eff * ((h == 0) ? 1 : h);
            write_setup(random_kernel_row(), random_kernel_row(), random_kernel_row(), w, h);
            if (count > 1 && $urandom_range(0, 4) == 0)
            begin
                count = $urandom_range(1, count - 1);
                for (i = 0; i < count; i++)
                    send_pixel(random_pixel());
                write_setup(random_kernel_row(), random_kernel_row(), random_kernel_row(),
                            dim_t'($urandom_range(0, w_eff)), dim_t'($urandom_range(0, 6)));
                finish_image();
            end
            else
            begin
                count = count * $urandom_range(1, 2);
                for (i = 0; i < count; i++)
                begin
                    if ($urandom_range(0, 49) == 0)
                        pause_sender();
                    send_pixel(random_pixel());
                end
            end
        end
        random_items = pixels_sent - first_sent;

        pause_sender();
        repeat (20) @(posedge clk);

        $display("Ran %0d pixels over %0d register setups: extreme sums, one-pixel images,",
                 pixels_sent, setups);
        $display("oversize and mid-image resizing, a steady stream, %0d random pixels.",
                 random_items);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
